[hw/rtl/hotp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hotp_pkg;

  localparam int unsigned WordW = 32;

  // Config register indexes.
  localparam logic CfgKeyUpper = 1'b0;
  localparam logic CfgKeyLower = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StRound,
    StAdd,
    StTrunc,
    StMod,
    StOut
  } ctrl_state_e;

  // Which of the four compressions is running.
  typedef enum logic [1:0] {
    PassInKey,
    PassInMsg,
    PassOutKey,
    PassOutMsg
  } pass_e;

  // Round unit control from the sequencer.
  typedef struct packed {
    logic       init;   // load chaining state with the SHA-1 IV (with load: working vars too)
    logic       load;   // load working vars from chaining state
    logic       round;  // run one round
    logic       add;    // fold working vars into chaining state
    logic [6:0] rnd;    // round number 0..79
  } round_ctrl_t;

  localparam logic [159:0] Sha1Iv =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20)      round_k = 32'h5A827999;
    else if (r < 7'd40) round_k = 32'h6ED9EBA1;
    else if (r < 7'd60) round_k = 32'h8F1BBCDC;
    else                round_k = 32'hCA62C1D6;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20)      round_f = (b & c) | (~b & d);
    else if (r < 7'd40) round_f = b ^ c ^ d;
    else if (r < 7'd60) round_f = (b & c) | (b & d) | (c & d);
    else                round_f = b ^ c ^ d;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/hotp_round.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared SHA-1 round unit: 16-word message schedule window and one round per cycle.
module hotp_round (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire hotp_pkg::round_ctrl_t  ctrl_i,
  input  wire logic [511:0]           block_i,
  output logic [159:0]                digest_o
);

  logic [159:0] h_q, h_d;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [511:0] w_q;
  logic [31:0]  w_cur, w_new, t_val;

  assign w_cur = w_q[511:480];
  assign w_new = hotp_pkg::rol32(w_q[511-2*32 -: 32] ^ w_q[511-8*32 -: 32] ^
                                 w_q[511-13*32 -: 32] ^ w_q[511 -: 32], 1);
  assign t_val = hotp_pkg::rol32(a_q, 5) + hotp_pkg::round_f(ctrl_i.rnd, b_q, c_q, d_q)
               + e_q + hotp_pkg::round_k(ctrl_i.rnd) + w_cur;

  always_comb begin
    h_d = h_q;
    if (ctrl_i.init) begin
      h_d = hotp_pkg::Sha1Iv;
    end else if (ctrl_i.add) begin
      h_d = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
             h_q[63:32] + d_q, h_q[31:0] + e_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
    end else begin
      h_q <= h_d;
    end
  end

  // init with load starts a fresh hash: working vars take the IV directly.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      {a_q, b_q, c_q, d_q, e_q} <= ctrl_i.init ? hotp_pkg::Sha1Iv : h_q;
      w_q <= block_i;
    end else if (ctrl_i.round) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= hotp_pkg::rol32(b_q, 30);
      b_q <= a_q;
      a_q <= t_val;
      w_q <= {w_q[479:0], w_new};
    end
  end

  assign digest_o = h_q;

endmodule
`default_nettype wire

[hw/rtl/hotp_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
// Reduction of a 31-bit value by a constant modulus through a reciprocal multiply.
// Quotient = (value * Recip) >> Shift, exact for every 31-bit value; then one
// multiply-subtract gives the remainder; done_o pulses when rem_o holds it.
module hotp_mod #(
  parameter int unsigned CODE_MODULUS = 1000000
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [30:0] value_i,
  output logic             done_o,
  output logic [31:0]      rem_o
);

  localparam int unsigned ModBits   = $clog2(CODE_MODULUS);
  localparam int unsigned Shift     = 31 + ModBits;
  localparam logic [63:0] ModWide   = 64'(CODE_MODULUS);
  localparam logic [63:0] RecipWide = ((64'd1 << Shift) + ModWide - 64'd1) / ModWide;
  localparam logic [32:0] Recip     = RecipWide[32:0];
  localparam logic [31:0] Mod32     = 32'(CODE_MODULUS);

  logic [30:0] val_q;
  logic [63:0] prod_q;
  logic [31:0] rem_q;
  logic        mul_q, sub_q;
  logic [31:0] quo, quo_mod;

  assign quo     = 32'(prod_q >> Shift);
  assign quo_mod = quo * Mod32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_o <= sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end
    if (mul_q) begin
      prod_q <= {33'd0, val_q} * {31'd0, Recip};
    end
    if (sub_q) begin
      rem_q <= {1'b0, val_q - quo_mod[30:0]};
    end
  end

  assign rem_o = rem_q;

endmodule
`default_nettype wire

[hw/rtl/hotp_code_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// HOTP code checker. Each item on s_axis carries a 64-bit moving factor and a
// claimed code; the block computes HMAC-SHA1 of the factor under the 80-bit key
// held in two config registers (index 0: key bytes 0..7, index 1: bytes 8..9),
// applies dynamic truncation, reduces modulo CODE_MODULUS and returns the code
// plus a match flag on m_axis. After acceptance, four SHA-1 compressions run
// through a single shared round unit at one round per cycle (each: load, 80
// rounds, fold), then truncation, reciprocal-multiply reduction and the move
// of the result into the output register; no new item is accepted before the
// last one has moved there. s_axis_tready is high only when no item is in
// flight; a result waiting in the output register does not block the next
// item, only the hand-over of the next result.
module hotp_code_checker #(
  parameter int unsigned KEY_BYTES    = 10,
  parameter int unsigned CODE_MODULUS = 1000000
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,   // [63:0] moving_factor, [83:64] claimed_code
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [0] code_matches, [20:1] computed_code
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  logic [63:0] key_upper_q;
  logic [15:0] key_lower_q;
  logic [63:0] mf_q;
  logic [19:0] claimed_q;
  logic [159:0] inner_q;

  hotp_pkg::ctrl_state_e state_q, state_d;
  hotp_pkg::pass_e       pass_q, pass_d;
  logic [6:0]            rnd_q, rnd_d;
  hotp_pkg::round_ctrl_t rctl;
  logic [511:0]          block;
  logic [159:0]          digest;
  logic                  mod_start, mod_done;
  logic [30:0]           bin;
  logic [31:0]           rem;
  logic                  out_valid_q;
  logic [23:0]           out_data_q;
  logic                  out_load;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == hotp_pkg::CfgKeyUpper) key_upper_q <= cfg_data_i;
      else                                      key_lower_q <= cfg_data_i[15:0];
    end
  end

  // Padded key block: key bytes past KEY_BYTES are zero.
  logic [511:0] key_blk;
  always_comb begin
    key_blk = '0;
    key_blk[511:432] = {key_upper_q, key_lower_q};
    for (int i = 0; i < 10; i++) begin
      if (i >= KEY_BYTES) key_blk[511-8*i -: 8] = 8'h00;
    end
  end

  always_comb begin
    case (pass_q)
      hotp_pkg::PassInKey:  block = key_blk ^ {64{8'h36}};
      hotp_pkg::PassInMsg:  block = {mf_q, 8'h80, 376'd0, 64'd576};
      hotp_pkg::PassOutKey: block = key_blk ^ {64{8'h5c}};
      hotp_pkg::PassOutMsg: block = {inner_q, 8'h80, 280'd0, 64'd672};
      default:              block = '0;
    endcase
  end

  hotp_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rctl),
    .block_i  (block),
    .digest_o (digest)
  );

  // Dynamic truncation on the outer digest.
  logic [3:0] off;
  assign off = digest[3:0];
  always_comb begin
    bin = '0;
    for (int o = 0; o < 16; o++) begin
      if (off == 4'(o)) bin = digest[158-8*o -: 31];
    end
  end

  hotp_mod #(.CODE_MODULUS(CODE_MODULUS)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (bin),
    .done_o  (mod_done),
    .rem_o   (rem)
  );

  // Result moves to the output register once that register is free or being taken.
  assign out_load = (state_q == hotp_pkg::StOut) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    rnd_d     = rnd_q;
    rctl      = '0;
    rctl.rnd  = rnd_q;
    mod_start = 1'b0;
    case (state_q)
      hotp_pkg::StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          rctl.init = 1'b1;
          pass_d    = hotp_pkg::PassInKey;
          state_d   = hotp_pkg::StLoad;
        end
      end
      hotp_pkg::StLoad: begin
        rctl.load = 1'b1;
        // outer hash starts over from the IV
        rctl.init = (pass_q == hotp_pkg::PassOutKey);
        rnd_d     = '0;
        state_d   = hotp_pkg::StRound;
      end
      hotp_pkg::StRound: begin
        rctl.round = 1'b1;
        rnd_d      = rnd_q + 7'd1;
        if (rnd_q == 7'd79) state_d = hotp_pkg::StAdd;
      end
      hotp_pkg::StAdd: begin
        rctl.add = 1'b1;
        state_d  = hotp_pkg::StLoad;
        case (pass_q)
          hotp_pkg::PassInKey:  pass_d = hotp_pkg::PassInMsg;
          hotp_pkg::PassInMsg:  pass_d = hotp_pkg::PassOutKey;
          hotp_pkg::PassOutKey: pass_d = hotp_pkg::PassOutMsg;
          default:              state_d = hotp_pkg::StTrunc;
        endcase
      end
      hotp_pkg::StTrunc: begin
        mod_start = 1'b1;
        state_d   = hotp_pkg::StMod;
      end
      hotp_pkg::StMod: begin
        if (mod_done) state_d = hotp_pkg::StOut;
      end
      hotp_pkg::StOut: begin
        if (out_load) state_d = hotp_pkg::StIdle;
      end
      default: state_d = hotp_pkg::StIdle;
    endcase
  end

  // Inner digest is captured as the outer key pass loads; the same edge puts
  // the chaining state back to the IV.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mf_q      <= s_axis_tdata[63:0];
      claimed_q <= s_axis_tdata[83:64];
    end
    if (state_q == hotp_pkg::StLoad && pass_q == hotp_pkg::PassOutKey) begin
      inner_q <= digest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hotp_pkg::StIdle;
      pass_q  <= hotp_pkg::PassInKey;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Match is decided on the full code; only 20 bits of it are returned.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {3'd0, rem[19:0], (rem == {12'd0, claimed_q})};
    end
  end

  assign s_axis_tready = (state_q == hotp_pkg::StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
